// File: src/aba_pkg.sv
// Shared constants and types for the adaptive banded affine-gap aligner.
// Used by the controller, the datapath and the top level; no dependencies.

package aba_pkg;

	// Band and sequence sizing.
	localparam int BAND_WIDTH = 32;
	localparam int HALF       = BAND_WIDTH / 2;
	localparam int MAX_LEN    = 4096;
	localparam int ADDR_W     = $clog2(MAX_LEN);
	localparam int LEN_W      = $clog2(MAX_LEN + 1);
	localparam int IDX_W      = $clog2(BAND_WIDTH);
	localparam int POS_RAW_W  = $clog2(2 * MAX_LEN + BAND_WIDTH);
	localparam int SEND_W     = 14;
	localparam int POS_W      = (POS_RAW_W > SEND_W) ? POS_RAW_W : SEND_W;
	localparam int CNT_W      = (POS_W > IDX_W) ? POS_W : IDX_W;

	// Best-value search: groups of cells reduced in the first stage.
	localparam int GRP  = 8;
	localparam int NGRP = (BAND_WIDTH + GRP - 1) / GRP;

	// Cell values and bases.
	localparam int CELL_W = 16;
	localparam int SW     = 20;
	localparam logic [CELL_W-1:0] OFFSET = 16'h8000;
	localparam int BASE_W = 3;
	localparam logic [BASE_W-1:0] BASE_N = 3'd4;

	// Result field widths.
	localparam int SCORE_W = 15;
	localparam int FEND_W  = 13;

	// Configuration port.
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             init_clr;
		logic             init_rd;
		logic [IDX_W-1:0] idx;
		logic             set_dir;
		logic             comp;
		logic             capture;
		logic             empty;
	} aba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             closes;
		logic             empty;
		logic [POS_W-1:0] steps;
	} aba_status_t;

endpackage

// File: src/aba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module aba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/aba_ctrl.sv
// Controller state machine of the aligner: load, band setup, band steps, result.
// Depends on aba_pkg.

module aba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  aba_pkg::aba_status_t status,
	output aba_pkg::aba_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CLR,
		ST_INIT,
		ST_INIT_END,
		ST_DIR,
		ST_READ,
		ST_COMP,
		ST_TAIL1,
		ST_TAIL2,
		ST_FINISH
	} state_t;

	state_t                    state_q;
	logic [aba_pkg::CNT_W-1:0] cnt_q;
	logic                      empty_q;
	logic                      done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// Command decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.idx      = cnt_q[aba_pkg::IDX_W-1:0];
		cmd.empty    = empty_q;
		unique case (state_q)
			ST_IDLE:   cmd.load = start;
			ST_CLR:    cmd.init_clr = 1'b1;
			ST_INIT:   cmd.init_rd = 1'b1;
			ST_DIR:    cmd.set_dir = 1'b1;
			ST_COMP:   cmd.comp = 1'b1;
			ST_FINISH: cmd.capture = 1'b1;
			default: ;
		endcase
	end

	// State, counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			empty_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			unique case (state_q)
				ST_IDLE: begin
					if (start && status.closes) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					empty_q <= status.empty;
					state_q <= status.empty ? ST_FINISH : ST_CLR;
				end
				ST_CLR: begin
					cnt_q   <= '0;
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == aba_pkg::CNT_W'(aba_pkg::HALF - 1)) begin
						state_q <= ST_INIT_END;
					end
				end
				ST_INIT_END: state_q <= ST_DIR;
				ST_DIR: begin
					cnt_q   <= aba_pkg::CNT_W'(status.steps) - 1'b1;
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_COMP;
				ST_COMP: begin
					if (cnt_q == '0) begin
						state_q <= ST_TAIL1;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_TAIL1:  state_q <= ST_TAIL2;
				ST_TAIL2:  state_q <= ST_FINISH;
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// A result is a single-cycle strobe.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	// An item that closes both sequences starts an alignment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && status.closes) |=> busy)
		else $error("closing item did not start alignment");

	// Band steps continue until the step count runs out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && cnt_q != '0) |=> (state_q == ST_READ))
		else $error("band step loop ended early");

endmodule

// File: src/aba_dp.sv
// Datapath of the aligner: sequence stores, band cells, best-score search, registers.
// Depends on aba_pkg and aba_ram.

module aba_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          func,
	input  logic [aba_pkg::BASE_W-1:0]    base,
	input  logic                          has_base,
	input  logic                          last,
	input  logic                          cfg_we,
	input  logic [aba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aba_pkg::CFG_W-1:0]     cfg_data,
	input  aba_pkg::aba_cmd_t             cmd,
	output aba_pkg::aba_status_t          status,
	output logic [aba_pkg::SCORE_W-1:0]   best_score,
	output logic [aba_pkg::FEND_W-1:0]    first_end,
	output logic signed [aba_pkg::SEND_W-1:0] second_end
);

	localparam int BW = aba_pkg::BAND_WIDTH;
	localparam int SW = aba_pkg::SW;
	localparam int CW = aba_pkg::CELL_W;
	localparam int IW = aba_pkg::IDX_W;
	localparam int PW = aba_pkg::POS_W;

	// Widen a cell value to signed working width.
	function automatic logic signed [SW-1:0] cx(input logic [CW-1:0] x);
		return $signed({{(SW-CW){1'b0}}, x});
	endfunction

	// Sign-extend an 8-bit register.
	function automatic logic signed [SW-1:0] sx8(input logic [7:0] x);
		return $signed({{(SW-8){x[7]}}, x});
	endfunction

	// Floor at zero and saturate to the cell range.
	function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] top;
		top = $signed({{(SW-CW){1'b0}}, {CW{1'b1}}});
		if (v < 0) return '0;
		else if (v > top) return {CW{1'b1}};
		else return v[CW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// Configuration registers.
	logic [6:0] match_q;
	logic [7:0] mismatch_q, gap_open_q, gap_ext_q;

	// Sequence bookkeeping.
	logic [aba_pkg::LEN_W-1:0] flen_q, slen_q;
	logic                      fclosed_q, sclosed_q;

	// Band state.
	logic [CW-1:0]              s1_q [BW];
	logic [CW-1:0]              s2_q [BW];
	logic [CW-1:0]              gh_q [BW];
	logic [CW-1:0]              gv_q [BW];
	logic [aba_pkg::BASE_W-1:0] ba_q [BW];
	logic [aba_pkg::BASE_W-1:0] bb_q [BW];
	logic                       prev_down_q;
	logic [PW-1:0]              apos_q, bpos_q;
	logic signed [SW-1:0]       acc_q;

	// Setup pipeline after the store read.
	logic          init_v_s1;
	logic [IW-1:0] idx_s1;

	// Best tracking.
	logic                 cells_new_q;
	logic                 red_v_s1;
	logic [CW-1:0]        gmax_s1 [aba_pkg::NGRP];
	logic [IW-1:0]        gidx_s1 [aba_pkg::NGRP];
	logic [CW-1:0]        best_q;
	logic [PW-1:0]        amax_q, bmax_q;

	// Result registers.
	logic [aba_pkg::SCORE_W-1:0]       res_score_q;
	logic [aba_pkg::FEND_W-1:0]        res_fend_q;
	logic [aba_pkg::SEND_W-1:0]        res_send_q;

	// Store ports.
	logic                         fwe, swe;
	logic [aba_pkg::ADDR_W-1:0]   fraddr, sraddr;
	logic [aba_pkg::BASE_W-1:0]   rda, rdb;
	logic                         fclosed_n, sclosed_n;

	// Combinational cell results.
	logic                         right;
	logic [aba_pkg::BASE_W-1:0]   nb_a, nb_b;
	logic [aba_pkg::BASE_W-1:0]   a_n [BW];
	logic [aba_pkg::BASE_W-1:0]   b_n [BW];
	logic [CW-1:0]                ns [BW];
	logic [CW-1:0]                nh [BW];
	logic [CW-1:0]                nv [BW];
	logic signed [SW-1:0]         go_x, ge_x, mm_x, match_x, mis_x;

	// Best-search combinational results.
	logic [CW-1:0] gmax [aba_pkg::NGRP];
	logic [IW-1:0] gidx [aba_pkg::NGRP];
	logic [CW-1:0] tmax;
	logic [IW-1:0] tidx;

	assign go_x    = sx8(gap_open_q);
	assign ge_x    = sx8(gap_ext_q);
	assign match_x = $signed({{(SW-7){1'b0}}, match_q});
	assign mis_x   = sx8(mismatch_q);
	assign mm_x    = smax(match_x, mis_x);

	// Status toward the controller.
	assign fclosed_n     = fclosed_q | (!func & last);
	assign sclosed_n     = sclosed_q | (func & last);
	assign status.closes = fclosed_n & sclosed_n;
	assign status.empty  = (flen_q == '0) || (slen_q == '0);
	assign status.steps  = PW'(flen_q) + PW'(slen_q) - 1'b1;

	// Store writes during loading.
	assign fwe = cmd.load && !func && has_base && !fclosed_q
		&& (flen_q < aba_pkg::LEN_W'(aba_pkg::MAX_LEN));
	assign swe = cmd.load && func && has_base && !sclosed_q
		&& (slen_q < aba_pkg::LEN_W'(aba_pkg::MAX_LEN));
	assign fraddr = cmd.init_rd ? aba_pkg::ADDR_W'(cmd.idx) : apos_q[aba_pkg::ADDR_W-1:0];
	assign sraddr = cmd.init_rd ? aba_pkg::ADDR_W'(cmd.idx) : bpos_q[aba_pkg::ADDR_W-1:0];

	aba_ram #(.WIDTH(aba_pkg::BASE_W), .DEPTH(aba_pkg::MAX_LEN)) u_first_ram (
		.clk   (clk),
		.we    (fwe),
		.waddr (flen_q[aba_pkg::ADDR_W-1:0]),
		.wdata (base),
		.raddr (fraddr),
		.rdata (rda)
	);

	aba_ram #(.WIDTH(aba_pkg::BASE_W), .DEPTH(aba_pkg::MAX_LEN)) u_second_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (slen_q[aba_pkg::ADDR_W-1:0]),
		.wdata (base),
		.raddr (sraddr),
		.rdata (rdb)
	);

	// Band direction and the bases entering the band.
	assign right = !(s1_q[BW-1] > s1_q[0]);
	assign nb_a  = (apos_q < PW'(flen_q)) ? rda : aba_pkg::BASE_N;
	assign nb_b  = (bpos_q < PW'(slen_q)) ? rdb : aba_pkg::BASE_N;

	// One anti-diagonal of band cells, one lane per cell.
	always_comb begin
		int im1, ip1;
		logic signed [SW-1:0] ph, pe, pv, pf, pd, ps, e, f, t;
		for (int i = 0; i < BW; i++) begin
			im1 = (i > 0) ? i - 1 : 0;
			ip1 = (i < BW - 1) ? i + 1 : BW - 1;
			a_n[i] = right ? ((i == 0) ? nb_a : ba_q[im1]) : ba_q[i];
			b_n[i] = right ? bb_q[i] : ((i == BW - 1) ? nb_b : bb_q[ip1]);
			if (right) begin
				ph = cx(s1_q[i]);
				pe = cx(gh_q[i]);
				pv = (i > 0) ? cx(s1_q[im1]) : '0;
				pf = (i > 0) ? cx(gv_q[im1]) : '0;
				pd = prev_down_q ? cx(s2_q[i]) : ((i > 0) ? cx(s2_q[im1]) : '0);
			end else begin
				pv = cx(s1_q[i]);
				pf = cx(gv_q[i]);
				ph = (i < BW - 1) ? cx(s1_q[ip1]) : '0;
				pe = (i < BW - 1) ? cx(gh_q[ip1]) : '0;
				pd = !prev_down_q ? cx(s2_q[i]) : ((i < BW - 1) ? cx(s2_q[ip1]) : '0);
			end
			ps = ((a_n[i] < aba_pkg::BASE_N) && (a_n[i] == b_n[i])) ? match_x : mis_x;
			e = cx(sat(smax(ph + go_x, pe) + ge_x));
			f = cx(sat(smax(pv + go_x, pf) + ge_x));
			t = smax(pd + ps, '0);
			nh[i] = e[CW-1:0];
			nv[i] = f[CW-1:0];
			ns[i] = sat(smax(t, smax(e, f)));
		end
	end

	// First search stage: best cell and its lowest index within each group.
	always_comb begin
		for (int g = 0; g < aba_pkg::NGRP; g++) begin
			gmax[g] = s1_q[g * aba_pkg::GRP];
			gidx[g] = IW'(g * aba_pkg::GRP);
			for (int j = 1; j < aba_pkg::GRP; j++) begin
				if (g * aba_pkg::GRP + j < BW) begin
					if (s1_q[(g * aba_pkg::GRP + j < BW) ? g * aba_pkg::GRP + j : 0]
							> gmax[g]) begin
						gmax[g] = s1_q[(g * aba_pkg::GRP + j < BW) ?
							g * aba_pkg::GRP + j : 0];
						gidx[g] = IW'(g * aba_pkg::GRP + j);
					end
				end
			end
		end
	end

	// Second search stage across the groups.
	always_comb begin
		tmax = gmax_s1[0];
		tidx = gidx_s1[0];
		for (int g = 1; g < aba_pkg::NGRP; g++) begin
			if (gmax_s1[g] > tmax) begin
				tmax = gmax_s1[g];
				tidx = gidx_s1[g];
			end
		end
	end

	// Control registers: configuration, lengths, pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 7'd1;
			mismatch_q  <= 8'hff;
			gap_open_q  <= 8'hff;
			gap_ext_q   <= 8'hff;
			flen_q      <= '0;
			slen_q      <= '0;
			fclosed_q   <= 1'b0;
			sclosed_q   <= 1'b0;
			init_v_s1   <= 1'b0;
			cells_new_q <= 1'b0;
			red_v_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					aba_pkg::REG_MATCH:    match_q    <= cfg_data[6:0];
					aba_pkg::REG_MISMATCH: mismatch_q <= cfg_data;
					aba_pkg::REG_GAP_OPEN: gap_open_q <= cfg_data;
					aba_pkg::REG_GAP_EXT:  gap_ext_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture) begin
				flen_q    <= '0;
				slen_q    <= '0;
				fclosed_q <= 1'b0;
				sclosed_q <= 1'b0;
			end else if (cmd.load) begin
				if (fwe) flen_q <= flen_q + 1'b1;
				if (swe) slen_q <= slen_q + 1'b1;
				fclosed_q <= fclosed_n;
				sclosed_q <= sclosed_n;
			end
			init_v_s1   <= cmd.init_rd;
			cells_new_q <= cmd.comp;
			red_v_s1    <= cells_new_q;
		end
	end

	// Band state, setup values and best tracking.
	always_ff @(posedge clk) begin
		idx_s1 <= cmd.idx;
		if (cells_new_q) begin
			gmax_s1 <= gmax;
			gidx_s1 <= gidx;
		end
		if (cmd.init_clr) begin
			for (int i = 0; i < BW; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
				gh_q[i] <= '0;
				gv_q[i] <= '0;
				ba_q[i] <= '0;
				bb_q[i] <= '0;
			end
			acc_q  <= '0;
			best_q <= aba_pkg::OFFSET;
			amax_q <= '0;
			bmax_q <= '0;
		end else if (init_v_s1) begin
			// Initial band pattern, one position from each band center per cycle.
			for (int i = 0; i < BW; i++) begin
				if (IW'(i) == IW'(aba_pkg::HALF - 1) - idx_s1) begin
					s2_q[i] <= sat(cx(aba_pkg::OFFSET) + acc_q - mm_x + ge_x + ge_x + go_x);
					s1_q[i] <= sat(cx(aba_pkg::OFFSET) + acc_q + go_x + ge_x);
					ba_q[i] <= (aba_pkg::LEN_W'(idx_s1) < flen_q) ? rda : aba_pkg::BASE_N;
				end
				if (IW'(i) == IW'(aba_pkg::HALF) + idx_s1) begin
					s2_q[i] <= sat(cx(aba_pkg::OFFSET) + acc_q
						+ ((idx_s1 != '0) ? go_x : '0));
					s1_q[i] <= sat(cx(aba_pkg::OFFSET) + acc_q + go_x + ge_x);
					bb_q[i] <= (aba_pkg::LEN_W'(idx_s1) < slen_q) ? rdb : aba_pkg::BASE_N;
				end
			end
			if (idx_s1 == '0) begin
				gh_q[aba_pkg::HALF - 1] <= sat(cx(aba_pkg::OFFSET) + go_x + ge_x);
				gv_q[aba_pkg::HALF]     <= sat(cx(aba_pkg::OFFSET) + go_x + ge_x);
			end
			acc_q <= acc_q - mm_x + ge_x + ge_x;
		end else if (cmd.set_dir) begin
			prev_down_q <= (s2_q[BW-1] > s2_q[0]);
			apos_q      <= PW'(aba_pkg::HALF);
			bpos_q      <= PW'(aba_pkg::HALF);
		end else if (cmd.comp) begin
			for (int i = 0; i < BW; i++) begin
				s2_q[i] <= s1_q[i];
				s1_q[i] <= ns[i];
				gh_q[i] <= nh[i];
				gv_q[i] <= nv[i];
				ba_q[i] <= a_n[i];
				bb_q[i] <= b_n[i];
			end
			prev_down_q <= !right;
			if (right) apos_q <= apos_q + 1'b1;
			else bpos_q <= bpos_q + 1'b1;
		end
		// The positions still belong to the step being searched here.
		if (red_v_s1 && (tmax > best_q)) begin
			best_q <= tmax;
			amax_q <= apos_q - PW'(tidx);
			bmax_q <= bpos_q + PW'(tidx);
		end
		if (cmd.capture) begin
			if (cmd.empty) begin
				res_score_q <= '0;
				res_fend_q  <= '0;
				res_send_q  <= '0;
			end else begin
				res_score_q <= best_q[aba_pkg::SCORE_W-1:0];
				res_fend_q  <= amax_q[aba_pkg::FEND_W-1:0];
				res_send_q  <= aba_pkg::SEND_W'(bmax_q - PW'(BW - 1));
			end
		end
	end

	assign best_score = res_score_q;
	assign first_end  = res_fend_q;
	assign second_end = $signed(res_send_q);

	// The best value never drops below the offset during an alignment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(red_v_s1 && $past(cells_new_q)) |-> (best_q >= aba_pkg::OFFSET))
		else $error("best value below offset");

endmodule

// File: src/adaptive_band_affine_align_top.sv
// Adaptive banded affine-gap aligner: a load/align command interface and one result.
// Depends on aba_pkg, aba_ctrl and aba_dp.

// An item is taken when start is high and busy is low; loading takes one item per
// cycle with busy staying low. The item that closes the second of the two sequences
// starts the alignment: busy then stays high through the band setup (one read of
// each sequence store per cycle), then through M + N - 1 band steps, where M and N
// are the sequence lengths, each of which reads the next base from the store in one
// state and updates all band cells in the cycle after, and then through the tail
// states that finish the best-score search. The result appears on best_score,
// first_end and second_end for exactly one cycle with done high, in the cycle in
// which busy falls, and the receiver cannot hold it off. If either sequence is
// empty, busy stays high only through the preparation and finish states, and the
// all-zero result is on the ports with done high in the cycle in which busy falls.

module adaptive_band_affine_align_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [aba_pkg::BASE_W-1:0]        base,
	input  logic                              has_base,
	input  logic                              last,
	input  logic                              cfg_we,
	input  logic [aba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aba_pkg::CFG_W-1:0]         cfg_data,
	output logic                              done,
	output logic [aba_pkg::SCORE_W-1:0]       best_score,
	output logic [aba_pkg::FEND_W-1:0]        first_end,
	output logic signed [aba_pkg::SEND_W-1:0] second_end
);

	aba_pkg::aba_cmd_t    cmd;
	aba_pkg::aba_status_t status;

	aba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd)
	);

	aba_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.base       (base),
		.has_base   (has_base),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.best_score (best_score),
		.first_end  (first_end),
		.second_end (second_end)
	);

endmodule

// File: dv/aba_align_checker.sv
// Checker for the adaptive banded affine-gap aligner: watches the item, write and result ports.
// Predicts every result from its own copy of the sequences and registers; depends on aba_pkg.
`timescale 1ns / 100ps

module aba_align_checker
	import aba_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      func,
	input  logic [BASE_W-1:0]         base,
	input  logic                      has_base,
	input  logic                      last,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      done,
	input  logic [SCORE_W-1:0]        best_score,
	input  logic [FEND_W-1:0]         first_end,
	input  logic signed [SEND_W-1:0]  second_end,
	output int                        mismatches,
	output int                        pending
);

	// Band step directions: right or down, after a right or a down step.
	localparam int DIR_RR = 0;
	localparam int DIR_RD = 1;
	localparam int DIR_DR = 2;
	localparam int DIR_DD = 3;
	localparam int CELL_OFS = 32768;
	localparam int CELL_TOP = 65535;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [FEND_W-1:0]  fend;
		logic [SEND_W-1:0]  send;
	} align_result_t;

	align_result_t alignment_results[$];

	logic [BASE_W-1:0] first_bases [MAX_LEN];
	logic [BASE_W-1:0] second_bases [MAX_LEN];
	int first_count, second_count;
	bit first_done, second_done;
	int match_val, mismatch_val, open_val, extend_val;

	function automatic int clamp_cell(int v);
		return v < 0 ? 0 : (v > CELL_TOP ? CELL_TOP : v);
	endfunction

	function automatic int gap_cost(int k);
		return (k > 0 ? open_val : 0) + k * extend_val;
	endfunction

	function automatic int base_score(logic [BASE_W-1:0] x, logic [BASE_W-1:0] y);
		return (x < BASE_N && x == y) ? match_val : mismatch_val;
	endfunction

	// Runs the whole banded alignment over the stored sequences.
	function automatic align_result_t predict_alignment();
		int s2 [BAND_WIDTH], s1 [BAND_WIDTH], gh [BAND_WIDTH], gv [BAND_WIDTH];
		int ns [BAND_WIDTH], nh [BAND_WIDTH], nv [BAND_WIDTH];
		logic [BASE_W-1:0] ba [BAND_WIDTH], bb [BAND_WIDTH], nb;
		int dir_next [2][4];
		int mm, top, dir, ph, pe, pv, pf, pd, e, f, v;
		longint apos, bpos, amax, bmax, steps;
		bit right;
		align_result_t r;
		dir_next = '{'{DIR_RR, DIR_DR, DIR_RR, DIR_DR}, '{DIR_RD, DIR_DD, DIR_RD, DIR_DD}};
		mm = match_val > mismatch_val ? match_val : mismatch_val;
		top = CELL_OFS;
		apos = HALF; bpos = HALF; amax = 0; bmax = 0;
		for (int i = 0; i < BAND_WIDTH; i++) begin
			s2[i] = 0; s1[i] = 0; gh[i] = 0; gv[i] = 0; ba[i] = 0; bb[i] = 0;
		end
		// Initial band pattern around the origin.
		for (int i = 0; i < HALF; i++) begin
			s2[HALF-1-i] = clamp_cell(CELL_OFS - (i + 1) * mm + gap_cost((i + 1) * 2));
			s2[HALF+i] = clamp_cell(CELL_OFS - i * mm + gap_cost(i * 2));
			s1[HALF-1-i] = clamp_cell(CELL_OFS - i * mm + gap_cost(i * 2 + 1));
			s1[HALF+i] = s1[HALF-1-i];
			if (i == 0) begin
				gh[HALF-1] = clamp_cell(CELL_OFS + gap_cost(1));
				gv[HALF] = clamp_cell(CELL_OFS + gap_cost(1));
			end
			ba[HALF-1-i] = i < first_count ? first_bases[i] : BASE_N;
			bb[HALF+i] = i < second_count ? second_bases[i] : BASE_N;
		end
		dir = s2[BAND_WIDTH-1] <= s2[0] ? DIR_RR : DIR_RD;
		steps = longint'(first_count) + second_count - 1;
		for (longint p = 0; p < steps; p++) begin
			dir = dir_next[s1[BAND_WIDTH-1] > s1[0] ? 1 : 0][dir];
			right = (dir == DIR_RR || dir == DIR_DR);
			// Shift in the next base of the sequence the band moves along.
			if (right) begin
				nb = apos < first_count ? first_bases[apos] : BASE_N;
				apos++;
				for (int i = BAND_WIDTH - 1; i > 0; i--) ba[i] = ba[i-1];
				ba[0] = nb;
			end else begin
				nb = bpos < second_count ? second_bases[bpos] : BASE_N;
				bpos++;
				for (int i = 0; i < BAND_WIDTH - 1; i++) bb[i] = bb[i+1];
				bb[BAND_WIDTH-1] = nb;
			end
			for (int i = 0; i < BAND_WIDTH; i++) begin
				if (right) begin
					ph = s1[i]; pe = gh[i];
					pv = i > 0 ? s1[i-1] : 0;
					pf = i > 0 ? gv[i-1] : 0;
					pd = (dir == DIR_RR) ? (i > 0 ? s2[i-1] : 0) : s2[i];
				end else begin
					pv = s1[i]; pf = gv[i];
					ph = i < BAND_WIDTH - 1 ? s1[i+1] : 0;
					pe = i < BAND_WIDTH - 1 ? gh[i+1] : 0;
					pd = (dir == DIR_RD) ? s2[i] : (i < BAND_WIDTH - 1 ? s2[i+1] : 0);
				end
				e = clamp_cell((ph + open_val > pe ? ph + open_val : pe) + extend_val);
				f = clamp_cell((pv + open_val > pf ? pv + open_val : pf) + extend_val);
				v = pd + base_score(ba[i], bb[i]);
				if (v < 0) v = 0;
				if (e > v) v = e;
				if (f > v) v = f;
				v = clamp_cell(v);
				ns[i] = v; nh[i] = e; nv[i] = f;
				if (v > top) begin
					top = v;
					amax = apos - i;
					bmax = bpos + i;
				end
			end
			s2 = s1; s1 = ns; gh = nh; gv = nv;
		end
		r.score = SCORE_W'(top - CELL_OFS);
		r.fend = FEND_W'(amax);
		r.send = SEND_W'(bmax - BAND_WIDTH + 1);
		return r;
	endfunction

	// Track writes and items, queue predictions and compare each result.
	always @(posedge clk or negedge arst_n) begin
		align_result_t got, want;
		if (!arst_n) begin
			first_count = 0; second_count = 0;
			first_done = 0; second_done = 0;
			match_val = 1; mismatch_val = -1; open_val = -1; extend_val = -1;
			alignment_results.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				got = '{best_score, first_end, second_end};
				if (alignment_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: score %0d first_end %0d second_end %0d",
							best_score, first_end, second_end);
					mismatches <= mismatches + 1;
				end else begin
					want = alignment_results.pop_front();
					if (got != want) begin
						if (mismatches < 10)
							$display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
								want.score, want.fend, $signed(want.send),
								got.score, got.fend, $signed(got.send));
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MATCH:    match_val = int'(cfg_data[6:0]);
					REG_MISMATCH: mismatch_val = int'($signed(cfg_data));
					REG_GAP_OPEN: open_val = int'($signed(cfg_data));
					REG_GAP_EXT:  extend_val = int'($signed(cfg_data));
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (!func) begin
					if (!first_done) begin
						if (has_base && first_count < MAX_LEN) begin
							first_bases[first_count] = base;
							first_count++;
						end
						if (last) first_done = 1;
					end
				end else if (!second_done) begin
					if (has_base && second_count < MAX_LEN) begin
						second_bases[second_count] = base;
						second_count++;
					end
					if (last) second_done = 1;
				end
				if (first_done && second_done) begin
					if (first_count == 0 || second_count == 0)
						alignment_results.push_back('0);
					else
						alignment_results.push_back(predict_alignment());
					first_count = 0; second_count = 0;
					first_done = 0; second_done = 0;
				end
			end
			pending <= alignment_results.size();
		end
	end

endmodule

// File: dv/adaptive_band_affine_align_top_tb.sv
// Testbench top for the adaptive banded affine-gap aligner: clock, reset, items and writes.
// Depends on aba_pkg, adaptive_band_affine_align_top and aba_align_checker.
`timescale 1ns / 100ps

module adaptive_band_affine_align_top_tb;
	import aba_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		bit              f;
		bit [BASE_W-1:0] b;
		bit              h;
		bit              l;
	} seq_item_t;

	logic clk, arst_n, start, busy, func, has_base, last, cfg_we, done;
	logic [BASE_W-1:0] base;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic [SCORE_W-1:0] best_score;
	logic [FEND_W-1:0] first_end;
	logic signed [SEND_W-1:0] second_end;
	int mismatches, pending, items_sent, idle_pct, quiet_cycles;

	adaptive_band_affine_align_top u_dut (.*);
	aba_align_checker u_checker (.*);

	// Clock.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Stall watchdog: cycles with neither an item nor a result.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bit [BASE_W-1:0] rand_base();
		return $urandom_range(9) == 0 ? $urandom_range(4, 7) : $urandom_range(0, 3);
	endfunction

	// Offer one item and hold it until taken, then maybe idle.
	task automatic send_item(seq_item_t it);
		int gap;
		start <= 1; func <= it.f; base <= it.b; has_base <= it.h; last <= it.l;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Build both sequences, the second mostly a mutated copy, and interleave them.
	task automatic send_pair(int la, int lb);
		seq_item_t qa[$], qb[$], it;
		bit [BASE_W-1:0] abases[$];
		int pick;
		for (int j = 0; j < la; j++) begin
			if ($urandom_range(19) == 0) qa.push_back('{0, rand_base(), 0, 0});
			abases.push_back(rand_base());
			qa.push_back('{0, abases[j], 1, j == la - 1});
		end
		if (la == 0) qa.push_back('{0, rand_base(), 0, 1});
		for (int j = 0; j < lb; j++) begin
			if ($urandom_range(19) == 0) qb.push_back('{1, rand_base(), 0, 0});
			it = '{1, rand_base(), 1, j == lb - 1};
			if (j < la && $urandom_range(9) < 7) it.b = abases[j];
			qb.push_back(it);
		end
		if (lb == 0) qb.push_back('{1, rand_base(), 0, 1});
		while (qa.size() + qb.size() > 0) begin
			// Items for an already closed sequence must be ignored.
			if ((qa.size() == 0 || qb.size() == 0) && $urandom_range(4) == 0)
				send_item('{qa.size() == 0 ? 1'b0 : 1'b1, rand_base(),
					1'($urandom_range(1)), 1'($urandom_range(1))});
			pick = qa.size() == 0 ? 1 : (qb.size() == 0 ? 0 : $urandom_range(1));
			if (pick == 0) send_item(qa.pop_front());
			else send_item(qb.pop_front());
		end
	endtask

	// Let every expected result arrive and the block settle.
	task automatic wait_idle();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(bit [6:0] m, bit [7:0] mis, bit [7:0] op, bit [7:0] ext);
		cfg_we <= 1; cfg_index <= REG_MATCH; cfg_data <= {1'($urandom_range(1)), m};
		@(posedge clk);
		cfg_index <= REG_MISMATCH; cfg_data <= mis;
		@(posedge clk);
		cfg_index <= REG_GAP_OPEN; cfg_data <= op;
		@(posedge clk);
		cfg_index <= REG_GAP_EXT; cfg_data <= ext;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int la, lb, r;
		arst_n = 0; start = 0; func = 0; base = '0; has_base = 0; last = 0;
		cfg_we = 0; cfg_index = REG_MATCH; cfg_data = '0;
		items_sent = 0; idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty sequences, a single base each, half a band width.
		send_pair(0, 3);
		send_pair(2, 0);
		send_pair(0, 0);
		send_pair(1, 1);
		send_pair(16, 16);

		// Random pairs over several register settings and idling patterns.
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			case (ph)
				0: write_regs(7'd127, -8'sd128, -8'sd127, -8'sd127);
				1: write_regs(7'd0, 8'd0, 8'd0, 8'd0);
				2: write_regs(7'd1, -8'sd1, -8'sd1, -8'sd1);
				default: write_regs($urandom_range(0, 127), -$urandom_range(0, 128),
					-$urandom_range(0, 127), -$urandom_range(0, 127));
			endcase
			case (ph % 4)
				1: idle_pct = 84;
				3: idle_pct = 12;
				default: idle_pct = 0;
			endcase
			while (items_sent < 25 + (ph + 1) * 240) begin
				r = $urandom_range(99);
				la = r < 4 ? 0 : (r < 9 ? $urandom_range(60, 200) : $urandom_range(1, 24));
				r = $urandom_range(99);
				lb = r < 4 ? 0 : (r < 9 ? $urandom_range(60, 200) : $urandom_range(1, 24));
				send_pair(la, lb);
			end
		end

		wait_idle();
		if (mismatches == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
